### src/sbc_pkg.sv
// Shared types and constants for the segment / box collision test.
// No dependencies; imported by every module of the block.
package sbc_pkg;

    localparam int SBC_CFG_W     = 23;
    localparam int SBC_COORD_W   = 24;
    localparam int SBC_IDX_W     = 2;
    localparam int SBC_NUM_AREAS = 12;

    // register indexes of the configuration port
    localparam logic [SBC_IDX_W-1:0] REG_DEPTH      = 2'd0;
    localparam logic [SBC_IDX_W-1:0] REG_HALF_WIDTH = 2'd1;
    localparam logic [SBC_IDX_W-1:0] REG_HEIGHT     = 2'd2;

    // sign of a value: neg, pos, or neither for zero
    typedef struct packed {
        logic neg;
        logic pos;
    } t_sgn;

    // end point position relative to the box planes
    typedef struct packed {
        t_sgn x;    // x
        t_sgn xd;   // x - depth
        t_sgn yh;   // y - half width
        t_sgn yn;   // y + half width
        t_sgn z;    // z
        t_sgn zh;   // z - height
    } t_pt_flags;

    // both signs strictly equal and nonzero
    function automatic logic same_strict(input t_sgn a, input t_sgn b);
        same_strict = (a.pos & b.pos) | (a.neg & b.neg);
    endfunction

endpackage

### src/sbc_area.sv
// Pipelined sign of a doubled triangle area (P1,P2,V) in one 2D projection.
// Four register stages: differences, partial products, products, sign.
// Depends on sbc_pkg.
module sbc_area import sbc_pkg::*; #(
    parameter int EW = SBC_COORD_W
) (
    input  logic                 i_clk,
    input  logic signed [EW-1:0] i_p1u,
    input  logic signed [EW-1:0] i_p1v,
    input  logic signed [EW-1:0] i_p2u,
    input  logic signed [EW-1:0] i_p2v,
    input  logic signed [EW-1:0] i_vu,
    input  logic signed [EW-1:0] i_vv,
    output t_sgn                 o_sign
);

    localparam int DW = EW + 1;
    localparam int K  = (DW + 1) / 2;
    localparam int PW = 2 * DW;

    // stage A: coordinate differences
    logic signed [DW-1:0] r_du, r_dv, r_wu, r_wv;
    always_ff @(posedge i_clk) begin
        r_du <= DW'(i_p2u) - DW'(i_p1u);
        r_dv <= DW'(i_p2v) - DW'(i_p1v);
        r_wu <= DW'(i_vu) - DW'(i_p1u);
        r_wv <= DW'(i_vv) - DW'(i_p1v);
    end

    // stage B: split each product into four half-width partial products
    logic signed [PW-1:0] r_hh [2];
    logic signed [PW-1:0] r_hl [2];
    logic signed [PW-1:0] r_lh [2];
    logic signed [PW-1:0] r_ll [2];
    logic signed [DW-1:0] w_a [2];
    logic signed [DW-1:0] w_b [2];

    assign w_a[0] = r_du;
    assign w_b[0] = r_wv;
    assign w_a[1] = r_wu;
    assign w_b[1] = r_dv;

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < 2; m++) begin
            r_hh[m] <= $signed(w_a[m][DW-1:K]) * $signed(w_b[m][DW-1:K]);
            r_hl[m] <= $signed(w_a[m][DW-1:K]) * $signed({1'b0, w_b[m][K-1:0]});
            r_lh[m] <= $signed({1'b0, w_a[m][K-1:0]}) * $signed(w_b[m][DW-1:K]);
            r_ll[m] <= $signed({1'b0, w_a[m][K-1:0]}) * $signed({1'b0, w_b[m][K-1:0]});
        end
    end

    // stage C: recombine partial products
    logic signed [PW-1:0] r_prod [2];
    always_ff @(posedge i_clk) begin
        for (int m = 0; m < 2; m++) begin
            r_prod[m] <= (r_hh[m] <<< (2 * K)) + ((r_hl[m] + r_lh[m]) <<< K) + r_ll[m];
        end
    end

    // stage D: subtract and take the sign
    logic signed [PW:0] w_diff;
    assign w_diff = (PW+1)'(r_prod[0]) - (PW+1)'(r_prod[1]);

    always_ff @(posedge i_clk) begin
        o_sign.neg <= w_diff[PW];
        o_sign.pos <= ~w_diff[PW] & (w_diff != '0);
    end

endmodule

### src/segment_box_collision_test_unit.sv
// Segment / box collision test, top level. Depends on sbc_pkg and sbc_area.
// The result strobes on o_done once a taken start has passed the input
// register, the four-stage area multiply pipeline and the output register.
// Throughput: one segment per cycle; busy stays low, results cannot stall.
// Reset (i_rst_n low, synchronous) clears the configuration registers, the
// valid bits and o_done to zero and drops all beats in flight.
module segment_box_collision_test_unit import sbc_pkg::*; #(
    parameter int COORD_WIDTH = SBC_COORD_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    output logic                          o_done,
    output logic                          o_collision,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [SBC_IDX_W-1:0]          i_cfg_index,
    input  logic [SBC_CFG_W-1:0]          i_cfg_data
);

    localparam int EW = (COORD_WIDTH > SBC_CFG_W + 1) ? COORD_WIDTH : SBC_CFG_W + 1;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [SBC_CFG_W-1:0] r_depth, r_half, r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_half   <= '0;
            r_height <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEPTH:      r_depth  <= i_cfg_data;
                REG_HALF_WIDTH: r_half   <= i_cfg_data;
                REG_HEIGHT:     r_height <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    logic signed [EW-1:0] w_d, w_h, w_hn, w_ht;
    assign w_d  = $signed(EW'(r_depth));
    assign w_h  = $signed(EW'(r_half));
    assign w_hn = -w_h;
    assign w_ht = $signed(EW'(r_height));

    // valid bits along the pipe
    logic [4:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[3:0], start & ~busy};
            o_done <= r_vld[4];
        end
    end

    // stage 0: capture the beat, sign-extended
    logic signed [EW-1:0] r_p [2][3];
    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_p[0][0] <= EW'(i_first_x);
            r_p[0][1] <= EW'(i_first_y);
            r_p[0][2] <= EW'(i_first_z);
            r_p[1][0] <= EW'(i_second_x);
            r_p[1][1] <= EW'(i_second_y);
            r_p[1][2] <= EW'(i_second_z);
        end
    end

    // area units: corners of the XZ, XY and YZ projections
    logic signed [EW-1:0] w_p1u [SBC_NUM_AREAS];
    logic signed [EW-1:0] w_p1v [SBC_NUM_AREAS];
    logic signed [EW-1:0] w_p2u [SBC_NUM_AREAS];
    logic signed [EW-1:0] w_p2v [SBC_NUM_AREAS];
    logic signed [EW-1:0] w_vu  [SBC_NUM_AREAS];
    logic signed [EW-1:0] w_vv  [SBC_NUM_AREAS];
    t_sgn                 w_ar  [SBC_NUM_AREAS];

    always_comb begin
        for (int k = 0; k < SBC_NUM_AREAS; k++) begin
            if (k < 4) begin
                w_p1u[k] = r_p[0][0]; w_p1v[k] = r_p[0][2];
                w_p2u[k] = r_p[1][0]; w_p2v[k] = r_p[1][2];
            end else if (k < 8) begin
                w_p1u[k] = r_p[0][0]; w_p1v[k] = r_p[0][1];
                w_p2u[k] = r_p[1][0]; w_p2v[k] = r_p[1][1];
            end else begin
                w_p1u[k] = r_p[0][1]; w_p1v[k] = r_p[0][2];
                w_p2u[k] = r_p[1][1]; w_p2v[k] = r_p[1][2];
            end
        end
        // XZ: (0,0) (0,ht) (d,ht) (d,0)
        w_vu[0]  = '0;   w_vv[0]  = '0;
        w_vu[1]  = '0;   w_vv[1]  = w_ht;
        w_vu[2]  = w_d;  w_vv[2]  = w_ht;
        w_vu[3]  = w_d;  w_vv[3]  = '0;
        // XY: (0,h) (0,-h) (d,h) (d,-h)
        w_vu[4]  = '0;   w_vv[4]  = w_h;
        w_vu[5]  = '0;   w_vv[5]  = w_hn;
        w_vu[6]  = w_d;  w_vv[6]  = w_h;
        w_vu[7]  = w_d;  w_vv[7]  = w_hn;
        // YZ: (h,0) (h,ht) (-h,0) (-h,ht)
        w_vu[8]  = w_h;  w_vv[8]  = '0;
        w_vu[9]  = w_h;  w_vv[9]  = w_ht;
        w_vu[10] = w_hn; w_vv[10] = '0;
        w_vu[11] = w_hn; w_vv[11] = w_ht;
    end

    for (genvar g = 0; g < SBC_NUM_AREAS; g++) begin : g_area
        sbc_area #(.EW(EW)) u_area (
            .i_clk  (i_clk),
            .i_p1u  (w_p1u[g]),
            .i_p1v  (w_p1v[g]),
            .i_p2u  (w_p2u[g]),
            .i_p2v  (w_p2v[g]),
            .i_vu   (w_vu[g]),
            .i_vv   (w_vv[g]),
            .o_sign (w_ar[g])
        );
    end

    // stage 1: end point signs against the box planes, then delay to stage 4
    function automatic t_sgn sgn_of(input logic signed [EW:0] v);
        sgn_of.neg = v[EW];
        sgn_of.pos = ~v[EW] & (v != '0);
    endfunction

    t_pt_flags w_fl [2];
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            w_fl[e].x  = sgn_of((EW+1)'(r_p[e][0]));
            w_fl[e].xd = sgn_of((EW+1)'(r_p[e][0]) - (EW+1)'(w_d));
            w_fl[e].yh = sgn_of((EW+1)'(r_p[e][1]) - (EW+1)'(w_h));
            w_fl[e].yn = sgn_of((EW+1)'(r_p[e][1]) + (EW+1)'(w_h));
            w_fl[e].z  = sgn_of((EW+1)'(r_p[e][2]));
            w_fl[e].zh = sgn_of((EW+1)'(r_p[e][2]) - (EW+1)'(w_ht));
        end
    end

    t_pt_flags r_fl [4][2];
    always_ff @(posedge i_clk) begin
        r_fl[0] <= w_fl;
        for (int s = 1; s < 4; s++) begin
            r_fl[s] <= r_fl[s-1];
        end
    end

    // stage 5: combine face tests
    logic      w_d_pos, w_h_pos, w_ht_pos;
    t_pt_flags w_a, w_b;
    logic      w_in_a, w_in_b;
    logic      w_front, w_top, w_rear, w_left, w_right;

    assign w_d_pos  = (r_depth != '0);
    assign w_h_pos  = (r_half != '0);
    assign w_ht_pos = (r_height != '0);
    assign w_a      = r_fl[3][0];
    assign w_b      = r_fl[3][1];

    assign w_in_a = w_a.x.pos & w_a.xd.neg & w_a.yn.pos & w_a.yh.neg & w_a.z.pos & w_a.zh.neg;
    assign w_in_b = w_b.x.pos & w_b.xd.neg & w_b.yn.pos & w_b.yh.neg & w_b.z.pos & w_b.zh.neg;

    assign w_front = ~same_strict(w_ar[0], w_ar[1]) & ~(w_ht_pos & same_strict(w_a.x, w_b.x))
                   & ~same_strict(w_ar[4], w_ar[5]) & ~(w_h_pos & same_strict(w_a.x, w_b.x));
    assign w_top   = ~same_strict(w_ar[1], w_ar[2]) & ~(w_d_pos & same_strict(w_a.zh, w_b.zh))
                   & ~same_strict(w_ar[4], w_ar[5]) & ~(w_h_pos & same_strict(w_a.x, w_b.x));
    assign w_rear  = ~same_strict(w_ar[2], w_ar[3]) & ~(w_ht_pos & same_strict(w_a.xd, w_b.xd))
                   & ~same_strict(w_ar[6], w_ar[7]) & ~(w_h_pos & same_strict(w_a.xd, w_b.xd));
    assign w_left  = ~same_strict(w_ar[8], w_ar[9]) & ~(w_ht_pos & same_strict(w_a.yh, w_b.yh))
                   & ~same_strict(w_ar[4], w_ar[6]) & ~(w_d_pos & same_strict(w_a.yh, w_b.yh));
    assign w_right = ~same_strict(w_ar[10], w_ar[11]) & ~(w_ht_pos & same_strict(w_a.yn, w_b.yn))
                   & ~same_strict(w_ar[5], w_ar[7]) & ~(w_d_pos & same_strict(w_a.yn, w_b.yn));

    always_ff @(posedge i_clk) begin
        o_collision <= (w_in_a & w_in_b) | w_front | w_top | w_rear | w_left | w_right;
    end

endmodule

### tb/sv/sbc_checker.sv
// Checker for the segment / box collision test: watches the start, result and
// configuration channels, predicts each collision flag and compares it.
// Depends on sbc_pkg.
module sbc_checker import sbc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [SBC_COORD_W-1:0] i_first_x,
    input  logic signed [SBC_COORD_W-1:0] i_first_y,
    input  logic signed [SBC_COORD_W-1:0] i_first_z,
    input  logic signed [SBC_COORD_W-1:0] i_second_x,
    input  logic signed [SBC_COORD_W-1:0] i_second_y,
    input  logic signed [SBC_COORD_W-1:0] i_second_z,
    input  logic                          o_done,
    input  logic                          o_collision,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [SBC_IDX_W-1:0]          i_cfg_index,
    input  logic [SBC_CFG_W-1:0]          i_cfg_data,
    output int                            fail_count,
    output int                            pending_count
);

    typedef logic signed [63:0] t_coord;
    typedef logic signed [127:0] t_area;

    logic [SBC_CFG_W-1:0] box_depth, box_half, box_height;
    logic                 hit_queue[$];

    // sign of doubled area of triangle (p, q, v): -1, 0 or 1
    function automatic int tri_sign(t_coord px, t_coord py, t_coord qx, t_coord qy,
                                    t_coord vx, t_coord vy);
        t_area a;
        a = t_area'(qx - px) * t_area'(vy - py) - t_area'(vx - px) * t_area'(qy - py);
        return (a == 0) ? 0 : ((a < 0) ? -1 : 1);
    endfunction

    function automatic bit both_same(int a, int b);
        return a != 0 && a == b;
    endfunction

    // 2D crossing test, touching and collinear count as hits
    function automatic bit cross_2d(t_coord p1x, t_coord p1y, t_coord p2x, t_coord p2y,
                                    t_coord v1x, t_coord v1y, t_coord v2x, t_coord v2y);
        if (both_same(tri_sign(p1x, p1y, p2x, p2y, v1x, v1y),
                      tri_sign(p1x, p1y, p2x, p2y, v2x, v2y)))
            return 0;
        if (both_same(tri_sign(v1x, v1y, v2x, v2y, p1x, p1y),
                      tri_sign(v1x, v1y, v2x, v2y, p2x, p2y)))
            return 0;
        return 1;
    endfunction

    function automatic bit strictly_in(t_coord x, t_coord y, t_coord z,
                                       t_coord d, t_coord h, t_coord t);
        return x > 0 && x < d && y > -h && y < h && z > 0 && z < t;
    endfunction

    function automatic bit predict_collision(t_coord ax, t_coord ay, t_coord az,
                                             t_coord bx, t_coord by, t_coord bz);
        t_coord d, h, t;
        d = t_coord'(box_depth);
        h = t_coord'(box_half);
        t = t_coord'(box_height);
        if (strictly_in(ax, ay, az, d, h, t) && strictly_in(bx, by, bz, d, h, t))
            return 1;
        return (cross_2d(ax, az, bx, bz, 0, 0, 0, t) &&
                cross_2d(ax, ay, bx, by, 0, h, 0, -h)) ||
               (cross_2d(ax, az, bx, bz, 0, t, d, t) &&
                cross_2d(ax, ay, bx, by, 0, h, 0, -h)) ||
               (cross_2d(ax, az, bx, bz, d, t, d, 0) &&
                cross_2d(ax, ay, bx, by, d, h, d, -h)) ||
               (cross_2d(ay, az, by, bz, h, 0, h, t) &&
                cross_2d(ax, ay, bx, by, 0, h, d, h)) ||
               (cross_2d(ay, az, by, bz, -h, 0, -h, t) &&
                cross_2d(ax, ay, bx, by, 0, -h, d, -h));
    endfunction

    assign pending_count = hit_queue.size();

    // track registers, queue predictions, compare result beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_depth  <= '0;
            box_half   <= '0;
            box_height <= '0;
            fail_count = 0;
            hit_queue.delete();
        end else begin
            if (o_done) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %0b",
                             $time, o_collision);
                    fail_count++;
                end else begin
                    if (o_collision !== hit_queue[0]) begin
                        $display("%0t: collision mismatch, expected %0b, actual %0b",
                                 $time, hit_queue[0], o_collision);
                        fail_count++;
                    end
                    void'(hit_queue.pop_front());
                end
            end
            if (start && !busy)
                hit_queue.push_back(predict_collision(i_first_x, i_first_y, i_first_z,
                                                      i_second_x, i_second_y, i_second_z));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEPTH:      box_depth  <= i_cfg_data;
                    REG_HALF_WIDTH: box_half   <= i_cfg_data;
                    REG_HEIGHT:     box_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/tb_top.sv
// Testbench top for segment_box_collision_test_unit: drives segments and
// register writes, instantiates the block and sbc_checker, gives the verdict.
// Depends on sbc_pkg, the block and sbc_checker.
module tb_top;
    import sbc_pkg::*;

    localparam int LATENCY = 5;
    localparam int CYCLE_LIMIT = 400000;

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          start = 0;
    logic                          busy;
    logic signed [SBC_COORD_W-1:0] fx = 0, fy = 0, fz = 0, sx = 0, sy = 0, sz = 0;
    logic                          o_done, o_collision;
    logic                          i_cfg_valid = 0;
    logic                          o_cfg_ready;
    logic [SBC_IDX_W-1:0]          i_cfg_index = REG_DEPTH;
    logic [SBC_CFG_W-1:0]          i_cfg_data = 0;
    int                            fail_count, pending_count;
    int                            cycle_count = 0;
    logic [SBC_CFG_W-1:0]          cur_d, cur_h, cur_t;

    segment_box_collision_test_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(fx), .i_first_y(fy), .i_first_z(fz),
        .i_second_x(sx), .i_second_y(sy), .i_second_z(sz),
        .o_done(o_done), .o_collision(o_collision),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    sbc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(fx), .i_first_y(fy), .i_first_z(fz),
        .i_second_x(sx), .i_second_y(sy), .i_second_z(sz),
        .o_done(o_done), .o_collision(o_collision),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // hold valid across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [SBC_IDX_W-1:0] idx, input logic [SBC_CFG_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_box(input logic [SBC_CFG_W-1:0] d, h, t);
        write_reg(REG_DEPTH, d);
        write_reg(REG_HALF_WIDTH, h);
        write_reg(REG_HEIGHT, t);
        i_cfg_valid <= 0;
        cur_d = d;
        cur_h = h;
        cur_t = t;
    endtask

    // hold start for one beat, then drop unless another follows at once
    task automatic send_segment(input logic signed [SBC_COORD_W-1:0] ax, ay, az, bx, by, bz,
                                input int gap);
        fx <= ax; fy <= ay; fz <= az; sx <= bx; sy <= by; sz <= bz;
        start <= 1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [SBC_COORD_W-1:0] rand_coord();
        return SBC_COORD_W'($urandom);
    endfunction

    // coordinate near the box, along one axis spanning lo..hi
    function automatic logic signed [SBC_COORD_W-1:0] near_coord(int lo, int hi);
        int r, span;
        r = $urandom_range(0, 9);
        span = hi - lo + 3;
        if (r == 0) return rand_coord();
        if (r == 1) return SBC_COORD_W'(($urandom_range(0, 1)) ? lo : hi);
        return SBC_COORD_W'(lo - 1 + int'($urandom_range(0, span - 1)));
    endfunction

    task automatic drain;
        start <= 0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    localparam logic signed [SBC_COORD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [SBC_COORD_W-1:0] CMIN = 24'sh800000;

    initial begin
        int g;
        bit burst;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // degenerate box right after reset
        cur_d = 0; cur_h = 0; cur_t = 0;
        send_segment(-5, 0, 0, 5, 0, 0, 0);
        send_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1);
        drain();

        // directed: unit box
        set_box(23'h10000, 23'h8000, 23'h10000);
        send_segment(100, 0, 100, 200, 10, 200, 0);          // both inside
        send_segment(0, 0, 100, 200, 10, 200, 0);            // end point on face
        send_segment(-100, 0, 100, 23'h20000, 0, 100, 0);    // passes through
        send_segment(-100, 23'h10000, 100, 23'h20000, 23'h10000, 100, 0); // misses
        send_segment(23'h10000, 0, 0, 23'h10000, 0, 23'h10000, 0);        // in rear face
        send_segment(-10, 23'h8000, 10, 23'h20000, 23'h8000, 10, 0);      // in left face
        send_segment(-10, -23'sh8000, 10, 23'h20000, -23'sh8000, 10, 0);  // in right face
        send_segment(100, 0, 23'h20000, 100, 0, -100, 0);    // through top
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
        send_segment(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0);
        send_segment(-1, -1, -1, -1, -1, -1, 0);
        send_segment(5, 5, 5, 5, 5, 5, 2);
        drain();

        // directed: extreme box
        set_box(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
        send_segment(1, 1, 1, CMAX - 1, 1, 1, 0);
        send_segment(CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, 0);
        send_segment(CMIN, 0, CMIN, CMIN, 0, CMAX, 0);
        drain();

        // random phases over several box settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: set_box(SBC_CFG_W'($urandom_range(1, 200)),
                           SBC_CFG_W'($urandom_range(1, 200)),
                           SBC_CFG_W'($urandom_range(1, 200)));
                1: set_box(SBC_CFG_W'($urandom), SBC_CFG_W'($urandom),
                           SBC_CFG_W'($urandom));
                2: set_box(0, SBC_CFG_W'($urandom_range(0, 50)),
                           SBC_CFG_W'($urandom_range(0, 50)));
                default: set_box(SBC_CFG_W'($urandom_range(1000, 100000)),
                                 SBC_CFG_W'($urandom_range(1000, 100000)),
                                 $urandom_range(0, 1) ? 23'h0 : 23'h7FFFFF);
            endcase
            burst = 0;
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(0, 19) == 0) burst = !burst;
                g = pick_gap(burst);
                if ($urandom_range(0, 5) == 0 || cur_d > 23'h200000)
                    send_segment(rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord(), rand_coord(), g);
                else
                    send_segment(near_coord(0, cur_d), near_coord(-int'(cur_h), cur_h),
                                 near_coord(0, cur_t), near_coord(0, cur_d),
                                 near_coord(-int'(cur_h), cur_h), near_coord(0, cur_t), g);
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
